[hdl/pcbd_pkg.sv]
// Shared constants, action codes and controller/datapath interface types for the dimmer.
package pcbd_pkg;

	localparam int PULSE_TOP     = 32;
	localparam int TABLE_ENTRIES = 30;
	localparam int TABLE_MAX     = 32;

	localparam int LVL_W = 5;
	localparam int CNT_W = $clog2(PULSE_TOP + 1);
	localparam int THR_W = 9;

	localparam logic [LVL_W-1:0] LVL_CAP = 5'd31;

	localparam logic [1:0] REQ_BRIGHT = 2'd0;
	localparam logic [1:0] REQ_CLOSE  = 2'd1;
	localparam logic [1:0] REQ_OPEN   = 2'd2;

	localparam logic [1:0] ACT_PULSE  = 2'd0;
	localparam logic [1:0] ACT_LOW    = 2'd1;
	localparam logic [1:0] ACT_SETTLE = 2'd2;

	localparam logic [THR_W-1:0] THRESH [TABLE_MAX] = '{
		9'd30,  9'd35,  9'd40,  9'd45,  9'd50,  9'd56,  9'd63,  9'd72,
		9'd80,  9'd87,  9'd100, 9'd109, 9'd114, 9'd120, 9'd130, 9'd138,
		9'd146, 9'd154, 9'd162, 9'd170, 9'd178, 9'd186, 9'd194, 9'd202,
		9'd210, 9'd218, 9'd226, 9'd234, 9'd242, 9'd256, 9'd256, 9'd256
	};

	typedef struct packed {
		logic       load;
		logic       emit;
		logic       dec;
		logic [1:0] act;
		logic       last;
	} cmd_t;

	typedef struct packed {
		logic go;
		logic go_low;
		logic slot_free;
		logic run_end;
	} status_t;

endpackage

[hdl/pcbd_dp.sv]
// Datapath: level mapping, stored levels, pulse counter and output word register.
module pcbd_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pcbd_pkg::cmd_t                cmd,
	output pcbd_pkg::status_t             status,
	input  logic [1:0]                    req_type,
	input  logic [7:0]                    brightness_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    line_action,
	output logic [pcbd_pkg::LVL_W-1:0]    new_level,
	output logic                          last
);
	import pcbd_pkg::*;

	logic [LVL_W-1:0] cur_q;
	logic [LVL_W-1:0] saved_q;
	logic             lid_open_q;
	logic [LVL_W-1:0] lvl_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic [1:0]       act_q;
	logic [LVL_W-1:0] level_q;
	logic             last_q;

	logic [THR_W-1:0] val_ext;
	logic [LVL_W:0]   idx;
	logic [LVL_W:0]   idx_sum;
	logic [LVL_W-1:0] mapped;
	logic [LVL_W-1:0] prog_lvl;
	logic [LVL_W-1:0] cur_d;
	logic [LVL_W-1:0] saved_d;
	logic             lid_d;
	logic             go;

	assign val_ext = {1'b0, brightness_value};

	always_comb begin
		idx = (LVL_W+1)'(TABLE_ENTRIES - 1);
		for (int j = TABLE_MAX - 1; j >= 1; j--) begin
			if (j <= TABLE_ENTRIES - 1 && val_ext < THRESH[j]) begin
				idx = (LVL_W+1)'(j - 1);
			end
		end
		idx_sum = idx + (LVL_W+1)'(2);
		if (val_ext < THRESH[0]) begin
			mapped = (brightness_value != 8'd0) ? LVL_W'(1) : '0;
		end else if (idx_sum > {1'b0, LVL_CAP}) begin
			mapped = LVL_CAP;
		end else begin
			mapped = idx_sum[LVL_W-1:0];
		end
	end

	always_comb begin
		cur_d    = cur_q;
		saved_d  = saved_q;
		lid_d    = lid_open_q;
		prog_lvl = '0;
		go       = 1'b0;
		case (req_type)
			REQ_BRIGHT: begin
				prog_lvl = mapped;
				cur_d    = mapped;
				go       = lid_open_q && (mapped != cur_q);
			end
			REQ_CLOSE: begin
				saved_d  = cur_q;
				prog_lvl = '0;
				cur_d    = '0;
				go       = lid_open_q;
				lid_d    = 1'b0;
			end
			REQ_OPEN: begin
				prog_lvl = (cur_q != '0) ? cur_q : saved_q;
				cur_d    = prog_lvl;
				go       = 1'b1;
				lid_d    = 1'b1;
			end
			default: begin
				go = 1'b0;
			end
		endcase
	end

	assign status.go        = go;
	assign status.go_low    = (prog_lvl == '0);
	assign status.slot_free = !out_valid_q || !out_stall;
	assign status.run_end   = (cnt_q == CNT_W'(lvl_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			saved_q     <= '0;
			lid_open_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				cur_q      <= cur_d;
				saved_q    <= saved_d;
				lid_open_q <= lid_d;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && go) begin
			lvl_q <= prog_lvl;
			cnt_q <= CNT_W'(PULSE_TOP);
		end else if (cmd.dec) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
		if (cmd.emit) begin
			act_q   <= cmd.act;
			level_q <= lvl_q;
			last_q  <= cmd.last;
		end
	end

	assign out_valid   = out_valid_q;
	assign line_action = act_q;
	assign new_level   = level_q;
	assign last        = last_q;

endmodule

[hdl/pcbd_ctrl.sv]
// Controller: sequences pulse runs, settle and hold-low words.
module pcbd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  pcbd_pkg::status_t   status,
	output pcbd_pkg::cmd_t      cmd
);
	import pcbd_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_PULSE  = 2'd1;
	localparam logic [1:0] ST_SETTLE = 2'd2;
	localparam logic [1:0] ST_LOW    = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.emit = 1'b0;
		cmd.dec  = 1'b0;
		cmd.act  = ACT_PULSE;
		cmd.last = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (status.go) begin
						state_d = status.go_low ? ST_LOW : ST_PULSE;
					end
				end
			end
			ST_PULSE: begin
				if (status.slot_free) begin
					cmd.emit = 1'b1;
					cmd.dec  = 1'b1;
					if (status.run_end) begin
						state_d = ST_SETTLE;
					end
				end
			end
			ST_SETTLE: begin
				if (status.slot_free) begin
					cmd.emit = 1'b1;
					cmd.act  = ACT_SETTLE;
					cmd.last = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_LOW: begin
				if (status.slot_free) begin
					cmd.emit = 1'b1;
					cmd.act  = ACT_LOW;
					cmd.last = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[hdl/pulse_count_backlight_dimmer.sv]
// Top level of the pulse-count backlight dimmer.
// One request word is taken while the controller is idle. A brightness request
// that changes the level L with the lid open gives PULSE_TOP+1-L pulse words and
// a settle word, a request to level 0 gives one hold-low word, and a request
// with no result gives no word. The block stays busy until its last word is in
// the single output word register, which takes one result word per cycle while
// the output is not stalled.
module pulse_count_backlight_dimmer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    req_type,
	input  logic [7:0]                    brightness_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    line_action,
	output logic [pcbd_pkg::LVL_W-1:0]    new_level,
	output logic                          last
);
	import pcbd_pkg::*;

	cmd_t    cmd;
	status_t status;

	pcbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	pcbd_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.req_type         (req_type),
		.brightness_value (brightness_value),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.line_action      (line_action),
		.new_level        (new_level),
		.last             (last)
	);

	a_pulse_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_action == ACT_PULSE |-> !last)
		else $error("pulse word marked last");

	a_low_is_off: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_action == ACT_LOW |-> last && new_level == '0)
		else $error("hold-low word with nonzero level or not last");

	a_settle_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_action == ACT_SETTLE |-> last && new_level != '0)
		else $error("settle word malformed");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !cmd.emit && !in_stall)
		else $error("word loaded while emitting");

endmodule
